/* design/bwc_pkg.sv */
// Package: widths, payload types and register indexes for the box wall collision block.
package bwc_pkg;

  localparam int CW       = 32;
  localparam int FW       = 16;
  localparam int CFG_IW   = 3;
  localparam int NSUB     = 12;
  localparam int NAXIS    = 3;
  localparam int NSTAGE   = NSUB * NAXIS;
  localparam int STEPS    = CW / 4;

  typedef enum logic [CFG_IW-1:0] {
    REG_LOW_X  = 3'd0,
    REG_HIGH_X = 3'd1,
    REG_LOW_Y  = 3'd2,
    REG_HIGH_Y = 3'd3,
    REG_LOW_Z  = 3'd4,
    REG_HIGH_Z = 3'd5,
    REG_FRIC   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic signed [CW-1:0] vel_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] new_vel_x;
    logic signed [CW-1:0] new_vel_y;
    logic signed [CW-1:0] new_vel_z;
    logic                 stuck;
  } out_t;

endpackage

/* design/box_wall_collision_friction_top.sv */
// Top level: pipelined box wall collision with Coulomb friction.
// Pipeline: 36 register stages, 12 per axis (x first, then y, then z).
// Throughput: one item per cycle; each stage holds one item and stalls only
// when it is full and the stage after it cannot take its item.
// Square root and divide run 8 bits per stage; walls and friction are registers.
// Reset (rst_ni low, async): stage valid bits, walls and friction clear to 0; stage data is not reset.
module box_wall_collision_friction_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bwc_pkg::CFG_IW-1:0]      cfg_idx_i,
  input  logic [bwc_pkg::CW-1:0]          cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bwc_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bwc_pkg::out_t                   out_data_o
);
  import bwc_pkg::*;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0][CW-1:0] v;
    logic               stuck;
    logic               done;
    logic               hit;
    logic [CW-1:0]      thr;
    logic [CW-1:0]      mb;
    logic [CW-1:0]      mc;
    logic [2*CW-1:0]    sqb;
    logic [2*CW-1:0]    sqc;
    logic [2*CW-1:0]    thrsq;
    logic [2*CW-1:0]    s;
    logic [CW+3:0]      srem;
    logic [CW-1:0]      root;
    logic [2*CW-1:0]    numb;
    logic [2*CW-1:0]    numc;
    logic [CW:0]        remb;
    logic [CW:0]        remc;
    logic [CW-1:0]      qb;
    logic [CW-1:0]      qc;
  } item_t;

  function automatic logic [CW-1:0] mag(input logic [CW-1:0] x);
    return x[CW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic item_t stage_op(input int a, input int sub, input item_t x,
                                     input logic [CW-1:0] lo, input logic [CW-1:0] hi,
                                     input logic [FW-1:0] f);
    item_t             y;
    int                b;
    int                c;
    int                j;
    int                i;
    logic              into;
    logic [CW+FW-1:0]  prod;
    logic [CW-1:0]     diff;
    logic [CW+3:0]     rem;
    logic [CW+3:0]     trial;
    logic [CW:0]       t;
    y    = x;
    b    = (a + 1) % NAXIS;
    c    = (a + 2) % NAXIS;
    into = 1'b0;
    prod = '0;
    diff = '0;
    rem  = '0;
    trial = '0;
    t    = '0;
    if (sub == 0) begin
      if ($signed(x.p[a]) <= $signed(lo)) begin
        into = x.v[a][CW-1];
      end else if ($signed(x.p[a]) >= $signed(hi)) begin
        into = !x.v[a][CW-1] && (x.v[a] != '0);
      end
      y.hit = into && !x.done;
      y.mb  = mag(x.v[b]);
      y.mc  = mag(x.v[c]);
      prod  = (CW+FW)'(f) * (CW+FW)'(mag(x.v[a]));
      y.thr = prod[CW+FW-1:FW];
    end else if (sub == 1) begin
      y.sqb   = (2*CW)'(x.mb) * (2*CW)'(x.mb);
      y.sqc   = (2*CW)'(x.mc) * (2*CW)'(x.mc);
      y.thrsq = (2*CW)'(x.thr) * (2*CW)'(x.thr);
    end else if (sub == 2) begin
      y.s    = x.sqb + x.sqc;
      y.srem = '0;
      y.root = '0;
      if (x.hit && (y.s <= x.thrsq)) begin
        y.v     = '0;
        y.stuck = 1'b1;
        y.done  = 1'b1;
        y.hit   = 1'b0;
      end
    end else if (sub <= 6) begin
      j = sub - 3;
      for (int m = 0; m < STEPS; m++) begin
        i     = CW - 1 - STEPS * j - m;
        rem   = {y.srem[CW+1:0], x.s[2*i+1 -: 2]};
        trial = {2'b00, y.root, 2'b01};
        if (rem >= trial) begin
          y.srem = rem - trial;
          y.root = {y.root[CW-2:0], 1'b1};
        end else begin
          y.srem = rem;
          y.root = {y.root[CW-2:0], 1'b0};
        end
      end
    end else if (sub == 7) begin
      diff   = x.root - x.thr;
      y.numb = (2*CW)'(x.mb) * (2*CW)'(diff);
      y.numc = (2*CW)'(x.mc) * (2*CW)'(diff);
      y.remb = {1'b0, y.numb[2*CW-1:CW]};
      y.remc = {1'b0, y.numc[2*CW-1:CW]};
      y.qb   = '0;
      y.qc   = '0;
    end else begin
      j = sub - 8;
      for (int m = 0; m < STEPS; m++) begin
        i = CW - 1 - STEPS * j - m;
        t = {y.remb[CW-1:0], x.numb[i]};
        if (t >= {1'b0, x.root}) begin
          y.remb  = t - {1'b0, x.root};
          y.qb[i] = 1'b1;
        end else begin
          y.remb = t;
        end
        t = {y.remc[CW-1:0], x.numc[i]};
        if (t >= {1'b0, x.root}) begin
          y.remc  = t - {1'b0, x.root};
          y.qc[i] = 1'b1;
        end else begin
          y.remc = t;
        end
      end
      if ((sub == NSUB - 1) && x.hit) begin
        y.v[a] = '0;
        y.v[b] = x.v[b][CW-1] ? (~y.qb + 1'b1) : y.qb;
        y.v[c] = x.v[c][CW-1] ? (~y.qc + 1'b1) : y.qc;
      end
    end
    return y;
  endfunction

  logic [2:0][CW-1:0] lo_q;
  logic [2:0][CW-1:0] hi_q;
  logic [FW-1:0]      fric_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= '0;
      fric_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOW_X:  lo_q[0] <= cfg_data_i;
        REG_HIGH_X: hi_q[0] <= cfg_data_i;
        REG_LOW_Y:  lo_q[1] <= cfg_data_i;
        REG_HIGH_Y: hi_q[1] <= cfg_data_i;
        REG_LOW_Z:  lo_q[2] <= cfg_data_i;
        REG_HIGH_Z: hi_q[2] <= cfg_data_i;
        REG_FRIC:   fric_q  <= cfg_data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  item_t              in_item;
  item_t [NSTAGE-1:0] data_q;
  logic  [NSTAGE-1:0] valid_q;
  logic  [NSTAGE:0]   rdy;

  always_comb begin
    in_item      = '0;
    in_item.p[0] = in_data_i.pos_x;
    in_item.p[1] = in_data_i.pos_y;
    in_item.p[2] = in_data_i.pos_z;
    in_item.v[0] = in_data_i.vel_x;
    in_item.v[1] = in_data_i.vel_y;
    in_item.v[2] = in_data_i.vel_z;
  end

  assign rdy[NSTAGE] = out_ready_i;

  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    localparam int Axis = k / NSUB;
    localparam int Sub  = k % NSUB;
    item_t stage_d;
    logic  valid_d;

    assign rdy[k] = !valid_q[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign stage_d = stage_op(Axis, Sub, in_item, lo_q[Axis], hi_q[Axis], fric_q);
      assign valid_d = in_valid_i;
    end else begin : g_next
      assign stage_d = stage_op(Axis, Sub, data_q[k-1], lo_q[Axis], hi_q[Axis], fric_q);
      assign valid_d = valid_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= valid_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && valid_d) begin
        data_q[k] <= stage_d;
      end
    end
  end

  assign in_ready_o           = rdy[0];
  assign out_valid_o          = valid_q[NSTAGE-1];
  assign out_data_o.new_vel_x = data_q[NSTAGE-1].v[0];
  assign out_data_o.new_vel_y = data_q[NSTAGE-1].v[1];
  assign out_data_o.new_vel_z = data_q[NSTAGE-1].v[2];
  assign out_data_o.stuck     = data_q[NSTAGE-1].stuck;

  a_stuck_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.stuck) |->
      (out_data_o.new_vel_x == '0 && out_data_o.new_vel_y == '0 &&
       out_data_o.new_vel_z == '0))
    else $error("stuck result with nonzero velocity");

  a_stall_only_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && (&valid_q)))
    else $error("input stalled without full pipeline");

  a_done_is_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (data_q[NSTAGE-1].done == data_q[NSTAGE-1].stuck &&
                     !(data_q[NSTAGE-1].done && data_q[NSTAGE-1].hit)))
    else $error("static stop flags inconsistent");

endmodule

/* dv/tb.sv */
// Testbench: box_wall_collision_friction_top checked item by item against an in-bench predictor.
`timescale 1ns / 1ps

module tb;
  import bwc_pkg::*;

  localparam int  LATENCY = 40;
  localparam longint LIMIT = 2000000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CW-1:0]   cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  in_t             in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_t            out_data_o;

  box_wall_collision_friction_top u_dut (.*);

  logic signed [CW-1:0] wall_lo [3];
  logic signed [CW-1:0] wall_hi [3];
  logic [FW-1:0]        fric;
  out_t                 vel_expected_q [$];
  int                   n_mismatch = 0;
  longint               n_cycles = 0;
  bit                   sink_busy_mode = 1'b1;
  int                   sink_hold = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > LIMIT) begin
      $display("** box_wall_collision_friction_top: FAILED **");
      $finish;
    end
  end

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_toward_zero(longint t, longint unsigned num,
                                               longint unsigned den);
    longint unsigned m;
    m = magnitude(t) * num / den;
    return t < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic out_t collide(in_t it);
    longint p [3];
    longint v [3];
    longint unsigned n, thr, s, len;
    bit into, stuck;
    int b, c;
    out_t r;
    stuck = 1'b0;
    p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
    v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
    for (int a = 0; a < 3; a++) begin
      b = (a + 1) % 3;
      c = (a + 2) % 3;
      if (p[a] <= longint'(wall_lo[a])) into = v[a] < 0;
      else if (p[a] >= longint'(wall_hi[a])) into = v[a] > 0;
      else continue;
      if (!into) continue;
      n = magnitude(v[a]);
      thr = (longint'(fric) * n) >> 16;
      s = magnitude(v[b]) * magnitude(v[b]) + magnitude(v[c]) * magnitude(v[c]);
      if (s <= thr * thr) begin
        v[0] = 0; v[1] = 0; v[2] = 0;
        stuck = 1'b1;
        break;
      end
      len = int_sqrt(s);
      v[a] = 0;
      v[b] = scale_toward_zero(v[b], len - thr, len);
      v[c] = scale_toward_zero(v[c], len - thr, len);
    end
    r.new_vel_x = v[0][CW-1:0];
    r.new_vel_y = v[1][CW-1:0];
    r.new_vel_z = v[2][CW-1:0];
    r.stuck = stuck;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (vel_expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        exp_r = vel_expected_q.pop_front();
        if (out_data_o.new_vel_x !== exp_r.new_vel_x || out_data_o.new_vel_y !== exp_r.new_vel_y
            || out_data_o.new_vel_z !== exp_r.new_vel_z || out_data_o.stuck !== exp_r.stuck) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                     exp_r.new_vel_x, exp_r.new_vel_y, exp_r.new_vel_z, exp_r.stuck,
                     out_data_o.new_vel_x, out_data_o.new_vel_y, out_data_o.new_vel_z,
                     out_data_o.stuck);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink stall pattern
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      out_ready_i <= 1'b0;
      sink_hold   <= sink_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (sink_busy_mode) sink_hold <= pick_gap();
    end
    if ($urandom_range(0, 299) == 0) sink_busy_mode <= ~sink_busy_mode;
  end

  task automatic send_particle(in_t it, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    vel_expected_q = {vel_expected_q, collide(it)};
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (vel_expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CW-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_LOW_X:  wall_lo[0] = d;
      REG_HIGH_X: wall_hi[0] = d;
      REG_LOW_Y:  wall_lo[1] = d;
      REG_HIGH_Y: wall_hi[1] = d;
      REG_LOW_Z:  wall_lo[2] = d;
      REG_HIGH_Z: wall_hi[2] = d;
      default:    fric = d[FW-1:0];
    endcase
  endtask

  task automatic set_box(logic [CW-1:0] lo, logic [CW-1:0] hi, logic [FW-1:0] f);
    drain();
    write_reg(REG_LOW_X, lo);  write_reg(REG_HIGH_X, hi);
    write_reg(REG_LOW_Y, lo);  write_reg(REG_HIGH_Y, hi);
    write_reg(REG_LOW_Z, lo);  write_reg(REG_HIGH_Z, hi);
    write_reg(REG_FRIC, f);
  endtask

  function automatic in_t particle(int px, int py, int pz, int vx, int vy, int vz);
    in_t it;
    it.pos_x = px; it.pos_y = py; it.pos_z = pz;
    it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
    return it;
  endfunction

  task automatic test_directed();
    localparam int ONE = 32'h10000;
    localparam int MIN = 32'h8000_0000;
    localparam int MAX = 32'h7fff_ffff;
    set_box(-10 * ONE, 10 * ONE, 16'h8000);
    send_particle(particle(0, 0, 0, ONE, -ONE, 3), 0);              // inside
    send_particle(particle(-10 * ONE, 0, 0, -ONE, 0, 0), 0);        // static, low wall
    send_particle(particle(11 * ONE, 0, 0, ONE, 5 * ONE, 0), 0);    // dynamic, high wall
    send_particle(particle(-20 * ONE, 0, 0, ONE, 5 * ONE, 0), 0);   // separating
    send_particle(particle(10 * ONE, 0, 0, 0, 5 * ONE, ONE), 0);    // tangential only
    send_particle(particle(0, 10 * ONE, 0, ONE, 2 * ONE, ONE), 1);
    send_particle(particle(0, 0, -10 * ONE, ONE, ONE, -3 * ONE), 0);
    send_particle(particle(MIN, MIN, MIN, -3 * ONE, -2 * ONE, -ONE), 0); // all axes
    send_particle(particle(MAX, MAX, MAX, MAX, MAX, MAX), 0);
    send_particle(particle(MIN, MAX, MIN, MIN, MIN, MIN), 2);
    send_particle(particle(MAX, MIN, 0, MAX, MIN, MAX), 0);
    send_particle(particle(MIN, 0, MAX, MIN, ONE / 4, -ONE / 4), 0);
    set_box(0, 0, 16'hffff);
    send_particle(particle(0, 0, 0, -ONE, ONE / 2, ONE / 2), 0);
    send_particle(particle(1, -1, 0, ONE, -ONE, ONE), 0);
    send_particle(particle(0, 0, 0, MIN, MAX, MIN), 0);
    set_box(5 * ONE, -5 * ONE, 16'h0000);                            // inverted box
    send_particle(particle(0, 0, 0, -ONE, ONE, 2 * ONE), 0);
    send_particle(particle(0, 0, 0, ONE, -ONE, -ONE), 0);
    send_particle(particle(6 * ONE, -6 * ONE, 0, ONE, -ONE, 0), 0);
    send_particle(particle(6 * ONE, 0, 0, ONE, 0, 0), 0);            // F=0, no tangent
  endtask

  function automatic logic [CW-1:0] near_wall(logic signed [CW-1:0] lo,
                                               logic signed [CW-1:0] hi);
    longint x;
    case ($urandom_range(0, 7))
      0: x = lo;
      1: x = hi;
      2: x = longint'(lo) - $urandom_range(1, 1 << 20);
      3: x = longint'(hi) + $urandom_range(1, 1 << 20);
      4: x = (longint'(lo) + longint'(hi)) / 2;
      5: x = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return $urandom;
    endcase
    if (x > 64'sh7fff_ffff) x = 64'sh7fff_ffff;
    if (x < -64'sh8000_0000) x = -64'sh8000_0000;
    return x[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] rand_vel();
    logic [CW-1:0] m;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3, 4: return $urandom;
      5: m = $urandom_range(0, 255);
      default: m = $urandom_range(0, 1 << 22);
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic test_random();
    logic [CW-1:0] lo, hi;
    in_t it;
    bit no_gaps;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
        1: begin lo = 32'hfff0_0000; hi = 32'h0010_0000; end
        default: begin lo = $urandom; hi = $urandom; end
      endcase
      drain();
      for (int r = 0; r < 7; r++) begin
        if (r == REG_FRIC)
          write_reg(cfg_reg_e'(r), ph == 0 ? 32'h0 : ph == 1 ? 32'hffff : $urandom);
        else if (ph < 2)
          write_reg(cfg_reg_e'(r), r % 2 ? hi : lo);
        else
          write_reg(cfg_reg_e'(r), $urandom_range(0, 3) == 0 ? $urandom : (r % 2 ? hi : lo));
      end
      no_gaps = 1'b0;
      for (int i = 0; i < 305; i++) begin
        it.pos_x = near_wall(wall_lo[0], wall_hi[0]);
        it.pos_y = near_wall(wall_lo[1], wall_hi[1]);
        it.pos_z = near_wall(wall_lo[2], wall_hi[2]);
        it.vel_x = rand_vel();
        it.vel_y = rand_vel();
        it.vel_z = rand_vel();
        if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
        if (i == 150) drain();    // hold off until all results are back
        send_particle(it, no_gaps ? 0 : pick_gap());
      end
    end
  endtask

  initial begin
    wall_lo = '{default: '0};
    wall_hi = '{default: '0};
    fric = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    drain();
    if (n_mismatch == 0 && vel_expected_q.size() == 0)
      $display("** box_wall_collision_friction_top: PASSED **");
    else
      $display("** box_wall_collision_friction_top: FAILED **");
    $finish;
  end

endmodule
